// File: hw/rtl/vt4_pkg.sv
// Shared constants, types and reset values for the 4x4 vertex transform core.
`default_nettype none
package vt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int LANES     = 4;
    localparam int FIX_W     = 32;
    localparam int PROD_W    = 2 * FIX_W;
    localparam int SUM_W     = PROD_W + $clog2(LANES);
    localparam int NUM_REGS  = 2 * LANES;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam int CFG_W     = 2 * FIX_W;

    localparam logic [FIX_W-1:0] FIX_ONE = FIX_W'(64'd1 << FRAC_BITS);
    localparam logic [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam logic [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

    typedef logic signed [FIX_W-1:0]  t_fix;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_fix t_vec [LANES];
    typedef t_sum t_sum_vec [LANES];

    typedef struct packed {
        logic en_mul;
        logic en_add;
        logic en_out;
    } t_pipe_ctl;

    // Identity matrix: 1.0 on the diagonal.
    // Diagonal entry r lives in register 2r + r/2, in the half picked by r's low bit.
    function automatic logic [CFG_W-1:0] cfg_reset(input int idx);
        logic [CFG_W-1:0] v;
        v = '0;
        for (int r = 0; r < LANES; r++) begin
            if (2 * r + r / 2 == idx) begin
                v[(r % 2) * FIX_W +: FIX_W] = FIX_ONE;
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vt4_lane.sv
// One row lane: four multipliers, then an exact adder stage.
`default_nettype none
module vt4_lane
    import vt4_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_vec      i_row,
    input  wire t_vec      i_vec,
    output t_sum           o_sum
);

    t_prod r_prod [LANES];
    t_sum  n_sum;
    t_sum  r_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            for (int c = 0; c < LANES; c++) begin
                if (c < DIM) begin
                    r_prod[c] <= t_prod'(i_row[c]) * t_prod'(i_vec[c]);
                end else begin
                    r_prod[c] <= '0;
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < LANES; c++) begin
            n_sum = n_sum + SUM_W'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_add) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// File: hw/rtl/vt4_merge.sv
// Merge stage: scale each lane sum, clip to 32 bits, collect the clip flag.
`default_nettype none
module vt4_merge
    import vt4_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_sum_vec i_sum,
    output t_vec          o_out,
    output logic          o_sat
);

    t_vec n_out;
    logic n_sat;
    t_vec r_out;
    logic r_sat;

    always_comb begin
        t_sum q;
        n_sat = 1'b0;
        for (int r = 0; r < LANES; r++) begin
            q = i_sum[r] >>> FRAC_BITS;
            // in range when the result's sign bit and all bits above it agree
            if (&q[SUM_W-1:FIX_W-1] || ~|q[SUM_W-1:FIX_W-1]) begin
                n_out[r] = q[FIX_W-1:0];
            end else begin
                n_out[r] = q[SUM_W-1] ? FIX_MIN : FIX_MAX;
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_out = r_out;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

// File: hw/rtl/vertex_transform_4x4_core.sv
// An accepted input beat passes the multiply, add and clip registers to its output beat.
// Throughput: one vector per cycle unless stalled; four 32x32 multipliers per row lane.
// Every stage holds its beat under backpressure and still fills behind a stalled output.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
`default_nettype none
module vertex_transform_4x4_core
    import vt4_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_fix                 i_vec_x,
    input  wire t_fix                 i_vec_y,
    input  wire t_fix                 i_vec_z,
    input  wire t_fix                 i_vec_w,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_fix                      o_out_x,
    output t_fix                      o_out_y,
    output t_fix                      o_out_z,
    output t_fix                      o_out_w,
    output logic                      o_saturated
);

    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    logic r_v_mul, r_v_add, r_v_out;
    logic rdy_mul, rdy_add, rdy_out;
    t_pipe_ctl ctl;
    t_vec     vec;
    t_vec     out;
    t_sum_vec sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= cfg_reset(i);
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign rdy_out = !r_v_out || i_ready;
    assign rdy_add = !r_v_add || rdy_out;
    assign rdy_mul = !r_v_mul || rdy_add;

    assign ctl.en_mul = rdy_mul;
    assign ctl.en_add = rdy_add;
    assign ctl.en_out = rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_add <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (rdy_mul) r_v_mul <= i_valid;
            if (rdy_add) r_v_add <= r_v_mul;
            if (rdy_out) r_v_out <= r_v_add;
        end
    end

    assign vec[0] = i_vec_x;
    assign vec[1] = i_vec_y;
    assign vec[2] = i_vec_z;
    assign vec[3] = i_vec_w;

    for (genvar r = 0; r < LANES; r++) begin : g_lane
        if (r < DIM) begin : g_on
            t_vec row;
            for (genvar c = 0; c < LANES; c++) begin : g_col
                assign row[c] = r_cfg[r * 2 + c / 2][(c % 2) * FIX_W +: FIX_W];
            end
            vt4_lane u_lane (
                .i_clk (i_clk),
                .i_ctl (ctl),
                .i_row (row),
                .i_vec (vec),
                .o_sum (sums[r])
            );
        end else begin : g_off
            assign sums[r] = '0;
        end
    end

    vt4_merge u_merge (
        .i_clk (i_clk),
        .i_en  (ctl.en_out),
        .i_sum (sums),
        .o_out (out),
        .o_sat (o_saturated)
    );

    assign o_ready = rdy_mul;
    assign o_valid = r_v_out;
    assign o_out_x = out[0];
    assign o_out_y = out[1];
    assign o_out_z = out[2];
    assign o_out_w = out[3];

endmodule
`default_nettype wire

// File: hw/rtl/vt4_checker.sv
// Port-level checks for the vertex transform core, bound to the top level.
`default_nettype none
module vt4_checker
    import vt4_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [CFG_W-1:0]     i_cfg_data,
    input wire logic                 i_valid,
    input wire logic                 o_ready,
    input wire t_fix                 i_vec_x,
    input wire t_fix                 i_vec_y,
    input wire t_fix                 i_vec_z,
    input wire t_fix                 i_vec_w,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire t_fix                 o_out_x,
    input wire t_fix                 o_out_y,
    input wire t_fix                 o_out_z,
    input wire t_fix                 o_out_w,
    input wire logic                 o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_w)
            && $stable(o_saturated))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty output stage");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_out_x == FIX_MAX || o_out_x == FIX_MIN || o_out_y == FIX_MAX
            || o_out_y == FIX_MIN || o_out_z == FIX_MAX || o_out_z == FIX_MIN
            || o_out_w == FIX_MAX || o_out_w == FIX_MIN)
        else $error("clip flag without a clipped component");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("beat did not reach the output in three cycles");

endmodule

bind vertex_transform_4x4_core vt4_checker u_vt4_checker (.*);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the 4x4 vertex transform core: random matrices and vectors, Q16.16.
`timescale 1ns / 1ps
module tb;
    import vt4_pkg::*;

    localparam int PIPE_LAT       = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 75;

    typedef logic signed [127:0] t_acc;
    localparam t_acc ACC_MAX = 128'sd2147483647;
    localparam t_acc ACC_MIN = -128'sd2147483648;

    localparam t_fix Q_ONE = FIX_ONE;
    localparam t_fix Q_TWO = FIX_ONE << 1;
    localparam t_fix Q_HI  = FIX_MAX;
    localparam t_fix Q_LO  = FIX_MIN;

    typedef struct packed {
        t_fix w;
        t_fix z;
        t_fix y;
        t_fix x;
    } t_vertex;

    typedef struct packed {
        logic sat;
        t_fix w;
        t_fix z;
        t_fix y;
        t_fix x;
    } t_xformed;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    t_fix                 i_vec_x    = '0;
    t_fix                 i_vec_y    = '0;
    t_fix                 i_vec_z    = '0;
    t_fix                 i_vec_w    = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    t_fix                 o_out_x;
    t_fix                 o_out_y;
    t_fix                 o_out_z;
    t_fix                 o_out_w;
    logic                 o_saturated;

    vertex_transform_4x4_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_vec_w     (i_vec_w),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w),
        .o_saturated (o_saturated)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the matrix registers, identity after reset
    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    t_fix             staged_coef [LANES][LANES];

    t_vertex  vertex_q [$];
    t_xformed xform_q [$];
    t_vertex  held;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    int       tx_gap = 0;
    int       rx_stall = 0;
    int       rx_hold = 0;
    int       results_seen = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    function automatic t_fix coef_at(int r, int c);
        return t_fix'(matrix_regs[r * 2 + c / 2][(c % 2) * FIX_W +: FIX_W]);
    endfunction

    // exact dot products, floor shift, clip to 32 bits
    function automatic t_xformed transform(t_vertex vtx);
        logic [LANES*FIX_W-1:0] lanes_in;
        logic [LANES*FIX_W-1:0] lanes_out;
        t_acc                   acc;
        logic                   clipped;
        lanes_in  = vtx;
        lanes_out = '0;
        clipped   = 1'b0;
        for (int r = 0; r < LANES; r++) begin
            if (r < DIM) begin
                acc = '0;
                for (int c = 0; c < DIM && c < LANES; c++)
                    acc = acc + t_acc'(coef_at(r, c))
                              * t_acc'(t_fix'(lanes_in[c*FIX_W +: FIX_W]));
                acc = acc >>> FRAC_BITS;
                if (acc > ACC_MAX) begin
                    lanes_out[r*FIX_W +: FIX_W] = FIX_MAX;
                    clipped = 1'b1;
                end else if (acc < ACC_MIN) begin
                    lanes_out[r*FIX_W +: FIX_W] = FIX_MIN;
                    clipped = 1'b1;
                end else begin
                    lanes_out[r*FIX_W +: FIX_W] = acc[FIX_W-1:0];
                end
            end
        end
        return {clipped, lanes_out};
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(int pct);
        int r;
        if ($urandom_range(99) >= pct)
            return 0;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_fix rand_coef();
        case ($urandom_range(9))
            0: return '0;
            1: return Q_HI;
            2: return Q_LO;
            3: return t_fix'($urandom());
            default: return t_fix'($urandom_range(0, 8 * 65536)) - 4 * Q_ONE;
        endcase
    endfunction

    function automatic t_fix rand_comp();
        case ($urandom_range(9))
            0: return Q_HI;
            1: return Q_LO;
            2, 3, 4: return t_fix'($urandom());
            default: return t_fix'($urandom_range(0, 1 << 21)) - t_fix'(1 << 20);
        endcase
    endfunction

    task automatic add_vertex(input t_fix x, input t_fix y, input t_fix z, input t_fix w);
        vertex_q.push_back('{x: x, y: y, z: z, w: w});
    endtask

    task automatic fill_coef(input t_fix val);
        for (int r = 0; r < LANES; r++)
            for (int c = 0; c < LANES; c++)
                staged_coef[r][c] = val;
    endtask

    task automatic load_matrix();
        logic [CFG_W-1:0] word;
        for (int i = 0; i < NUM_REGS; i++) begin
            word = {staged_coef[i / 2][(i % 2) * 2 + 1], staged_coef[i / 2][(i % 2) * 2]};
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= word;
            matrix_regs[i] = word;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the pipe to empty; the watchdog bounds this
    task automatic drain();
        @(negedge i_clk);
        while (vertex_q.size() != 0 || i_valid || xform_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 3) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready)
                xform_q.push_back(transform(held));
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (vertex_q.size() > 0) begin
                    held = vertex_q.pop_front();
                    i_vec_x <= held.x;
                    i_vec_y <= held.y;
                    i_vec_z <= held.z;
                    i_vec_w <= held.w;
                    i_valid <= 1'b1;
                    tx_gap = pick_gap(tx_idle_pct);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_xformed got;
        t_xformed want;
        logic     nxt_ready;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_saturated, o_out_w, o_out_z, o_out_y, o_out_x};
                results_seen++;
                // long hold so the pipe fills and backs up into the sender
                if (results_seen == 120 || results_seen == 330)
                    rx_hold = 48;
                if (xform_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: x=%h y=%h z=%h w=%h sat=%b",
                                 got.x, got.y, got.z, got.w, got.sat);
                end else begin
                    want = xform_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
                                     results_seen, want.x, want.y, want.z, want.w, want.sat,
                                     got.x, got.y, got.z, got.w, got.sat);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                nxt_ready = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                nxt_ready = 1'b0;
            end else begin
                rx_stall = pick_gap(rx_idle_pct);
                nxt_ready = (rx_stall == 0);
                if (rx_stall > 0)
                    rx_stall--;
            end
            i_ready <= nxt_ready;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = '0;
        matrix_regs[0] = {32'd0, FIX_ONE};
        matrix_regs[2] = {FIX_ONE, 32'd0};
        matrix_regs[5] = {32'd0, FIX_ONE};
        matrix_regs[7] = {FIX_ONE, 32'd0};
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset: output equals input, no clipping
        add_vertex('0, '0, '0, '0);
        add_vertex(Q_HI, Q_HI, Q_HI, Q_HI);
        add_vertex(Q_LO, Q_LO, Q_LO, Q_LO);
        add_vertex(Q_HI, Q_LO, -1, 1);
        add_vertex(t_fix'(32'h5555_5555), t_fix'(32'hAAAA_AAAA),
                   t_fix'(32'hAAAA_AAAA), t_fix'(32'h5555_5555));
        add_vertex(Q_ONE, -Q_ONE, Q_TWO, -Q_TWO);
        drain();

        // all entries at the positive extreme
        fill_coef(Q_HI);
        load_matrix();
        add_vertex(Q_HI, Q_HI, Q_HI, Q_HI);
        add_vertex(Q_LO, Q_LO, Q_LO, Q_LO);
        add_vertex(1, 0, 0, 0);
        add_vertex(-1, 0, 0, 0);
        add_vertex(0, 0, 0, 0);
        drain();

        // all entries at the negative extreme: largest exact sum
        fill_coef(Q_LO);
        load_matrix();
        add_vertex(Q_LO, Q_LO, Q_LO, Q_LO);
        add_vertex(Q_HI, Q_HI, Q_HI, Q_HI);
        add_vertex(1, 0, 0, 0);
        add_vertex(0, 0, -1, 0);
        drain();

        // +/-2.0 diagonal: clip boundaries off by one either way
        fill_coef('0);
        staged_coef[0][0] = Q_TWO;
        staged_coef[1][1] = -Q_TWO;
        staged_coef[2][2] = Q_TWO;
        staged_coef[3][3] = -Q_TWO;
        load_matrix();
        add_vertex(t_fix'(32'h4000_0000), t_fix'(32'h4000_0000),
                   t_fix'(32'h3FFF_FFFF), t_fix'(32'h4000_0001));
        add_vertex(t_fix'(32'h3FFF_FFFF), t_fix'(32'h4000_0001),
                   t_fix'(32'hC000_0000), t_fix'(32'hC000_0000));
        add_vertex(t_fix'(32'hBFFF_FFFF), t_fix'(32'hC000_0000), -1, 1);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int r = 0; r < LANES; r++)
                for (int c = 0; c < LANES; c++)
                    staged_coef[r][c] = rand_coef();
            load_matrix();
            if (p == 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (p == 3) begin
                tx_idle_pct = 50;
                rx_idle_pct = 50;
            end else begin
                tx_idle_pct = $urandom_range(5, 40);
                rx_idle_pct = $urandom_range(5, 40);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
                add_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            drain();
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
